// ===== rtl/htfd_pkg.sv =====
package htfd_pkg;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// Byte positions within the six-byte frame
	localparam logic [2:0] BYTE_T_HI  = 3'd0;
	localparam logic [2:0] BYTE_T_LO  = 3'd1;
	localparam logic [2:0] BYTE_T_CRC = 3'd2;
	localparam logic [2:0] BYTE_H_HI  = 3'd3;
	localparam logic [2:0] BYTE_H_LO  = 3'd4;
	localparam logic [2:0] BYTE_H_CRC = 3'd5;

	// Conversion scale factors
	localparam logic [14:0] TEMP_SPAN   = 15'd17500;
	localparam logic [13:0] HUM_SPAN    = 14'd10000;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;

	typedef struct packed {
		logic [15:0] raw_t;
		logic [15:0] raw_h;
		logic        t_ok;
		logic        h_ok;
	} frame_rec_t;

	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} frame_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// One byte of CRC-8, MSB first, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] c;
		c = crc_in ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/htfd_front.sv =====
module htfd_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   beat_ok,
	input  logic                   first_byte,
	input  logic [7:0]             rx_byte,
	output htfd_pkg::frame_push_t  push
);
	import htfd_pkg::*;

	logic [2:0]  count_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic [15:0] hum_word_q;
	logic        temp_ok_q;
	logic [2:0]  idx;

	// Restart on the flag; treat an impossible count as byte zero
	always_comb begin
		if (first_byte || (count_q > BYTE_H_CRC)) begin
			idx = BYTE_T_HI;
		end else begin
			idx = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= BYTE_T_HI;
			crc_q       <= CRC_INIT;
			temp_word_q <= '0;
			hum_word_q  <= '0;
			temp_ok_q   <= 1'b0;
		end else if (beat_ok) begin
			case (idx)
				BYTE_T_HI: begin
					crc_q             <= crc8_byte(CRC_INIT, rx_byte);
					temp_word_q[15:8] <= rx_byte;
				end
				BYTE_H_HI: begin
					crc_q            <= crc8_byte(CRC_INIT, rx_byte);
					hum_word_q[15:8] <= rx_byte;
				end
				BYTE_T_LO: begin
					crc_q            <= crc8_byte(crc_q, rx_byte);
					temp_word_q[7:0] <= rx_byte;
				end
				BYTE_H_LO: begin
					crc_q           <= crc8_byte(crc_q, rx_byte);
					hum_word_q[7:0] <= rx_byte;
				end
				BYTE_T_CRC: begin
					temp_ok_q <= (crc_q == rx_byte);
				end
				default: begin
				end
			endcase
			if (idx == BYTE_H_CRC) begin
				count_q <= BYTE_T_HI;
			end else begin
				count_q <= idx + 3'd1;
			end
		end
	end

	always_comb begin
		push.valid     = beat_ok && (idx == BYTE_H_CRC);
		push.rec.raw_t = temp_word_q;
		push.rec.raw_h = hum_word_q;
		push.rec.t_ok  = temp_ok_q;
		push.rec.h_ok  = (crc_q == rx_byte);
	end

endmodule

// ===== rtl/htfd_queue.sv =====
module htfd_queue #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  htfd_pkg::frame_push_t  push,
	input  logic                   pop,
	output htfd_pkg::frame_rec_t   head,
	output htfd_pkg::queue_stat_t  stat
);
	import htfd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	frame_rec_t    slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (cnt_q == FULL_CNT);
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push.valid && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/htfd_conv.sv =====
module htfd_conv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  htfd_pkg::frame_rec_t  q_rec,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [63:0]           m_tdata
);
	import htfd_pkg::*;

	logic        valid_s1;
	frame_rec_t  rec_s1;
	logic [30:0] prod_t_s1;
	logic [29:0] prod_h_s1;
	logic        s1_adv;
	logic        out_adv;

	logic [14:0] q1_t;
	logic [13:0] q1_h;
	logic [16:0] rem_t;
	logic [16:0] rem_h;
	logic [14:0] quo_t;
	logic [13:0] quo_h;
	logic [15:0] temp_sum;

	logic        m_valid_q;
	logic [63:0] m_data_q;

	assign out_adv = !m_valid_q || m_tready;
	assign s1_adv  = !valid_s1 || out_adv;
	assign pop     = q_valid && s1_adv;

	// Stage 1: scale the raw words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_s1    <= q_rec;
			prod_t_s1 <= 31'(q_rec.raw_t) * 31'(TEMP_SPAN);
			prod_h_s1 <= 30'(q_rec.raw_h) * 30'(HUM_SPAN);
		end
	end

	// Divide by 65535: estimate with >>16, then one correction step
	always_comb begin
		q1_t     = prod_t_s1[30:16];
		q1_h     = prod_h_s1[29:16];
		rem_t    = 17'(prod_t_s1[15:0]) + 17'(q1_t);
		rem_h    = 17'(prod_h_s1[15:0]) + 17'(q1_h);
		quo_t    = q1_t + 15'(rem_t >= FULL_SCALE);
		quo_h    = q1_h + 14'(rem_h >= FULL_SCALE);
		temp_sum = 16'(quo_t) - TEMP_OFFSET;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			m_data_q <= {rec_s1.t_ok & rec_s1.h_ok, rec_s1.h_ok, rec_s1.t_ok,
			             rec_s1.raw_h, rec_s1.raw_t, quo_h, temp_sum[14:0]};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== rtl/humidity_temp_frame_decoder.sv =====
// Humidity and temperature frame decoder. Feed the sensor's six-byte frame
// (T_hi T_lo T_crc H_hi H_lo H_crc) one byte per beat on the s_ side; set
// s_tuser on the first byte to restart framing, otherwise the byte counter
// wraps after the sixth byte on its own. Each byte pair is checked with
// CRC-8 (poly 0x31, init 0xFF) against its third byte. After the sixth byte
// one beat appears on the m_ side with the converted temperature
// (-4500 + floor(17500*raw/65535), hundredths of deg C), the humidity
// (floor(10000*raw/65535), hundredths of percent), both raw words and the
// CRC flags; a bad CRC still produces a result, flagged. Input takes one
// byte every cycle while s_tready is high: the CRC of a byte is finished
// in the cycle it is accepted. Finished frames go into a QUEUE_DEPTH-entry
// queue; the converter drains it at one frame per cycle unless m_tready
// holds it back, and a frame leaving the queue passes one multiply stage,
// then the divide-by-65535 correction into the output register, before it
// shows on m_. s_tready drops only while that queue is full.
module humidity_temp_frame_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [14:0] temperature_centi, [28:15] humidity_centi,
	                               // [44:29] raw_temperature, [60:45] raw_humidity,
	                               // [61] temp_crc_ok, [62] hum_crc_ok, [63] frame_ok
);
	import htfd_pkg::*;

	frame_push_t push;
	frame_rec_t  head;
	queue_stat_t stat;
	logic        pop;
	logic        beat_ok;

	// Hold off the sender only while the queue has no room
	assign s_tready = !stat.full;
	assign beat_ok  = s_tvalid && s_tready;

	// Front: framing, CRC and raw word capture
	htfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_ok    (beat_ok),
		.first_byte (s_tuser),
		.rx_byte    (s_tdata),
		.push       (push)
	);

	// Decouple frame capture from conversion
	htfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	// Back: scale, divide and drive the result beat
	htfd_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!stat.empty),
		.q_rec    (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// A finished frame never meets a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !stat.full)
		else $error("frame pushed into full queue");

	// The queue is never both full and empty
	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue status inconsistent");

	// frame_ok is the AND of both CRC flags
	a_frame_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63] == (m_tdata[61] & m_tdata[62])))
		else $error("frame_ok mismatch");

	// Humidity never exceeds full scale
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[28:15] <= 14'd10000))
		else $error("humidity out of range");

endmodule
